FILE: src/mask_ray_cast_assert.svh
// Assertion macros used by the mask ray cast back end.
`ifndef MASK_RAY_CAST_ASSERT_SVH
`define MASK_RAY_CAST_ASSERT_SVH
`ifndef SYNTHESIS
`define MRC_CHECK(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mask ray cast check failed");
`define MRC_CHECK_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mask ray cast check failed");
`else
`define MRC_CHECK(lbl, clk, rst_n, ante, cons)
`define MRC_CHECK_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: src/mrc_pkg.sv
// Types and constants shared by the mask ray cast modules.
package mrc_pkg;

    localparam int IDX_W     = 16;
    localparam int COORD_W   = 10;
    localparam int DIM_W     = 9;
    localparam int STEP_W    = 10;
    localparam int PROD_W    = 20;
    localparam int POS_W     = 12;
    localparam int ADDR_W    = 22;
    localparam int CFG_IDX_W = 1;
    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 24;

    localparam int COORD_MAX  = 2 ** (COORD_W - 1) - 1;
    localparam int COORD_MIN  = -(2 ** (COORD_W - 1));
    localparam int STEP_LIMIT = 2 ** (COORD_W - 1) + 1;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_CAST  = 1'b1
    } t_op;

    typedef struct packed {
        t_op                        op;
        logic [IDX_W-1:0]           idx;
        logic                       set;
        logic signed [COORD_W-1:0]  rx;
        logic signed [COORD_W-1:0]  ry;
        logic                       use_ext;
        logic signed [COORD_W-1:0]  ex;
        logic signed [COORD_W-1:0]  ey;
        logic [STEP_W-1:0]          ax;
        logic [STEP_W-1:0]          ay;
        logic [STEP_W-1:0]          bxa;
        logic [STEP_W-1:0]          bya;
        logic                       sx_neg;
        logic                       sy_neg;
        logic                       ax_zero;
        logic                       ay_zero;
        logic                       x_major;
    } t_cmd;

    typedef struct packed {
        logic                       hit;
        logic signed [COORD_W-1:0]  end_y;
        logic signed [COORD_W-1:0]  end_x;
    } t_result;

endpackage

FILE: src/mrc_front.sv
// Front end: takes input beats, decodes and classifies them into commands.
module mrc_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_hold,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic                         i_op,
    input  logic [mrc_pkg::S_TDATA_W-1:0] i_tdata,
    output logic                         o_valid,
    input  logic                         i_ready,
    output mrc_pkg::t_cmd                o_cmd
);
    import mrc_pkg::*;

    logic  r_valid;
    t_cmd  r_cmd;
    t_cmd  n_cmd;
    logic  push;

    function automatic logic [STEP_W-1:0] mag(input logic signed [COORD_W-1:0] c);
        logic [STEP_W-1:0] m;
        m = c[COORD_W-1] ? (~STEP_W'(c) + 1'b1) : STEP_W'(c);
        return m;
    endfunction

    // tdata: idx[15:0] set[16] rx[26:17] ry[36:27] ext[37] ex[47:38] ey[57:48]
    always_comb begin
        n_cmd         = '0;
        n_cmd.op      = t_op'(i_op);
        n_cmd.idx     = i_tdata[15:0];
        n_cmd.set     = i_tdata[16];
        n_cmd.rx      = i_tdata[26:17];
        n_cmd.ry      = i_tdata[36:27];
        n_cmd.use_ext = i_tdata[37];
        n_cmd.ex      = i_tdata[47:38];
        n_cmd.ey      = i_tdata[57:48];
        n_cmd.ax      = mag(n_cmd.rx);
        n_cmd.ay      = mag(n_cmd.ry);
        n_cmd.bxa     = mag(n_cmd.ex);
        n_cmd.bya     = mag(n_cmd.ey);
        n_cmd.sx_neg  = n_cmd.rx[COORD_W-1];
        n_cmd.sy_neg  = n_cmd.ry[COORD_W-1];
        n_cmd.ax_zero = (n_cmd.ax == '0);
        n_cmd.ay_zero = (n_cmd.ay == '0);
        n_cmd.x_major = (n_cmd.ay <= n_cmd.ax);
    end

    assign push    = r_valid && i_ready;
    assign o_ready = !i_hold && (!r_valid || i_ready);
    assign o_valid = r_valid;
    assign o_cmd   = r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

FILE: src/mrc_queue.sv
// Two-entry command queue between the front end and the walker.
module mrc_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  mrc_pkg::t_cmd i_data,
    output logic          o_full,
    output logic          o_valid,
    output mrc_pkg::t_cmd o_data,
    input  logic          i_pop
);
    import mrc_pkg::*;

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_slot [DEPTH];
    logic [PTR_W-1:0] r_wp;
    logic [PTR_W-1:0] r_rp;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_slot[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PTR_W'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == PTR_W'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_data;
        end
    end

endmodule

FILE: src/mrc_back.sv
// Back end: mask memory, clearing pass, pixel writes and the ray walker.
`include "mask_ray_cast_assert.svh"
module mrc_back #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [mrc_pkg::DIM_W-1:0]  i_width,
    input  logic [mrc_pkg::DIM_W-1:0]  i_height,
    input  logic                       i_cmd_valid,
    input  mrc_pkg::t_cmd              i_cmd,
    output logic                       o_cmd_pop,
    output logic                       o_clearing,
    output logic                       o_res_valid,
    input  logic                       i_res_ready,
    output mrc_pkg::t_result           o_res
);
    import mrc_pkg::*;

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_WALK,
        S_DONE
    } t_state;

    t_state                     r_state;
    logic [AW-1:0]              r_clr;
    t_cmd                       r_cmd;
    logic [STEP_W-1:0]          r_u;
    logic [STEP_W-1:0]          r_v;
    logic [PROD_W-1:0]          r_pu;
    logic [PROD_W-1:0]          r_pv;
    logic signed [POS_W-1:0]    r_col;
    logic signed [POS_W-1:0]    r_row;
    logic signed [ADDR_W-1:0]   r_addr;
    logic                       r_pend;
    logic                       r_inframe;
    t_result                    r_res;
    logic                       r_out_valid;
    t_result                    r_out;
    logic                       r_rd;

    logic                       mem [DEPTH];

    logic [DIM_W-1:0]           half_w;
    logic [DIM_W-1:0]           half_h;
    logic signed [ADDR_W-1:0]   w_a;
    logic signed [POS_W-1:0]    w_p;
    logic signed [POS_W-1:0]    h_p;
    logic                       hit_now;
    logic                       lim_now;
    logic                       du;
    logic                       dv;
    logic [STEP_W-1:0]          n_u;
    logic [STEP_W-1:0]          n_v;
    logic [PROD_W-1:0]          n_pu;
    logic [PROD_W-1:0]          n_pv;
    logic signed [POS_W-1:0]    d_col;
    logic signed [POS_W-1:0]    d_row;
    logic signed [POS_W-1:0]    n_col;
    logic signed [POS_W-1:0]    n_row;
    logic signed [ADDR_W-1:0]   d_addr;
    logic signed [ADDR_W-1:0]   n_addr;
    logic                       n_inframe;
    logic signed [STEP_W:0]     cu;
    logic signed [STEP_W:0]     cv;
    logic                       slot_free;
    logic                       start_cast;
    logic                       idx_ok;
    logic                       w_en;
    logic [AW-1:0]              w_addr;
    logic                       w_data;

    function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [STEP_W:0] c);
        logic signed [COORD_W-1:0] r;
        if (int'(c) > COORD_MAX) begin
            r = COORD_W'(COORD_MAX);
        end else if (int'(c) < COORD_MIN) begin
            r = COORD_W'(COORD_MIN);
        end else begin
            r = COORD_W'(c);
        end
        return r;
    endfunction

    assign half_w = i_width >> 1;
    assign half_h = i_height >> 1;
    assign w_a    = signed'(ADDR_W'(i_width));
    assign w_p    = signed'(POS_W'(i_width));
    assign h_p    = signed'(POS_W'(i_height));

    assign o_clearing  = (r_state == S_CLEAR);
    assign o_cmd_pop   = (r_state == S_IDLE) && i_cmd_valid;
    assign start_cast  = o_cmd_pop && (i_cmd.op == OP_CAST);
    assign idx_ok      = (32'(i_cmd.idx) < DEPTH);
    assign slot_free   = !r_out_valid || i_res_ready;
    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

    // evaluate the probe issued last cycle
    assign hit_now = r_pend && r_rd && r_inframe;
    assign lim_now = r_pend && ((r_u > r_cmd.ax) || (r_v > r_cmd.ay)) &&
                     (!r_cmd.use_ext || (r_u > r_cmd.bxa) || (r_v > r_cmd.bya));

    // one step of the digital line, all offsets kept incrementally
    always_comb begin
        du = 1'b0;
        dv = 1'b0;
        if (r_cmd.ax_zero) begin
            dv = 1'b1;
        end else if (r_cmd.ay_zero) begin
            du = 1'b1;
        end else if (r_cmd.x_major) begin
            du = 1'b1;
            dv = (r_pu > r_pv);
        end else begin
            dv = 1'b1;
            du = (r_pv > r_pu);
        end

        n_u  = r_u + STEP_W'(du);
        n_v  = r_v + STEP_W'(dv);
        n_pu = r_pu + (du ? PROD_W'(r_cmd.ay) : '0);
        n_pv = r_pv + (dv ? PROD_W'(r_cmd.ax) : '0);

        d_col = '0;
        if (du) begin
            d_col = r_cmd.sx_neg ? '1 : POS_W'(1);
        end
        // rows count downward while y counts upward
        d_row = '0;
        if (dv) begin
            d_row = r_cmd.sy_neg ? POS_W'(1) : '1;
        end
        n_col = r_col + d_col;
        n_row = r_row + d_row;

        d_addr = ADDR_W'(d_col);
        if (dv) begin
            d_addr = r_cmd.sy_neg ? (d_addr + w_a) : (d_addr - w_a);
        end
        n_addr = r_addr + d_addr;

        n_inframe = !n_col[POS_W-1] && (n_col < w_p) && !n_row[POS_W-1] && (n_row < h_p);

        cu = signed'({1'b0, r_u});
        if (r_cmd.sx_neg) begin
            cu = -cu;
        end
        cv = signed'({1'b0, r_v});
        if (r_cmd.sy_neg) begin
            cv = -cv;
        end
    end

    always_comb begin
        w_en   = 1'b0;
        w_addr = AW'(i_cmd.idx);
        w_data = i_cmd.set;
        if (r_state == S_CLEAR) begin
            w_en   = 1'b1;
            w_addr = r_clr;
            w_data = 1'b0;
        end else if (o_cmd_pop && (i_cmd.op == OP_WRITE) && idx_ok) begin
            w_en = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            mem[w_addr] <= w_data;
        end
        r_rd <= mem[n_addr[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // load a finished result, else drop the beat once taken
            if ((r_state == S_DONE) && slot_free) begin
                r_out_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == AW'(DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (start_cast) begin
                        r_cmd   <= i_cmd;
                        r_u     <= '0;
                        r_v     <= '0;
                        r_pu    <= '0;
                        r_pv    <= '0;
                        r_col   <= signed'(POS_W'(half_w));
                        r_row   <= signed'(POS_W'(half_h));
                        r_addr  <= signed'(ADDR_W'(half_h) * ADDR_W'(i_width) +
                                           ADDR_W'(half_w));
                        r_pend  <= 1'b0;
                        r_state <= S_WALK;
                    end
                end
                S_WALK: begin
                    if (hit_now) begin
                        r_res.end_x <= sat_coord(cu);
                        r_res.end_y <= sat_coord(cv);
                        r_res.hit   <= 1'b1;
                        r_state     <= S_DONE;
                    end else if (lim_now) begin
                        r_res.end_x <= r_cmd.use_ext ? r_cmd.ex : r_cmd.rx;
                        r_res.end_y <= r_cmd.use_ext ? r_cmd.ey : r_cmd.ry;
                        r_res.hit   <= 1'b0;
                        r_state     <= S_DONE;
                    end else begin
                        r_u       <= n_u;
                        r_v       <= n_v;
                        r_pu      <= n_pu;
                        r_pv      <= n_pv;
                        r_col     <= n_col;
                        r_row     <= n_row;
                        r_addr    <= n_addr;
                        r_inframe <= n_inframe;
                        r_pend    <= 1'b1;
                    end
                end
                S_DONE: begin
                    if (slot_free) begin
                        r_out   <= r_res;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_CLEAR;
                end
            endcase
        end
    end

    `MRC_CHECK(a_walk_bound, i_clk, i_rst_n, r_state == S_WALK, (r_u <= STEP_W'(STEP_LIMIT)) && (r_v <= STEP_W'(STEP_LIMIT)))
    `MRC_CHECK(a_cross_u, i_clk, i_rst_n, r_state == S_WALK, r_pu == PROD_W'(r_cmd.ay) * PROD_W'(r_u))
    `MRC_CHECK(a_cross_v, i_clk, i_rst_n, r_state == S_WALK, r_pv == PROD_W'(r_cmd.ax) * PROD_W'(r_v))
    `MRC_CHECK(a_addr_track, i_clk, i_rst_n, r_state == S_WALK, r_addr == ADDR_W'(r_row) * w_a + ADDR_W'(r_col))
    `MRC_CHECK_NEXT(a_cast_start, i_clk, i_rst_n, start_cast, (r_state == S_WALK) && !r_pend && (r_u == '0) && (r_v == '0))

endmodule

FILE: src/mask_ray_cast.sv
// Top level of the mask ray cast block: config registers and the front/queue/back chain.
//
// Input stream (s_axis): tuser is the opcode, 0 writes one mask pixel, 1 casts one ray.
// Output stream (m_axis): one beat per cast carrying the end point and the hit flag;
// pixel writes give no beat.
// Configuration: i_cfg_we with i_cfg_index 0 sets the frame width, 1 the frame height;
// write only while the block is idle.
// Reset: the mask memory is swept clear, one entry per cycle, and s_axis tready
// stays low until the sweep ends. Frame size returns to 256 by 256.
// Walker: a pixel write leaves the walker in its idle state. A cast walks up to
// 513 line steps; each step is one mask memory read, so the single memory read
// port sets the pace. A cast beat passes through the front-end register, the
// command queue, the walker and the output register before its result beat.
// A two-entry command queue sits between the decoder and the walker, so input
// beats keep flowing while a cast runs, up to the queue depth.
// When the receiver holds tready low, one finished result waits in the output
// register and the walker stops after its next result; input then backs up.
module mask_ray_cast #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // pixel_index[15:0] pixel_set[16] reach_x[26:17] reach_y[36:27]
    // use_extension[37] extended_x[47:38] extended_y[57:48], zero above
    input  logic [mrc_pkg::S_TDATA_W-1:0]   i_s_axis_tdata,
    // opcode[0]
    input  logic                            i_s_axis_tuser,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // end_x[9:0] end_y[19:10] hit[20], zero above
    output logic [mrc_pkg::M_TDATA_W-1:0]   o_m_axis_tdata,
    input  logic                            i_cfg_we,
    input  logic [mrc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [mrc_pkg::DIM_W-1:0]       i_cfg_wdata
);
    import mrc_pkg::*;

    logic [DIM_W-1:0] r_frame_width;
    logic [DIM_W-1:0] r_frame_height;
    logic [DIM_W-1:0] width_eff;
    logic [DIM_W-1:0] height_eff;

    logic    front_valid;
    t_cmd    front_cmd;
    logic    q_full;
    logic    q_valid;
    t_cmd    q_cmd;
    logic    q_pop;
    logic    clearing;
    t_result res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= DIM_W'(256);
            r_frame_height <= DIM_W'(256);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_FRAME_WIDTH:  r_frame_width  <= i_cfg_wdata;
                REG_FRAME_HEIGHT: r_frame_height <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // zero acts as one, oversize clamps to the memory geometry
    always_comb begin
        width_eff = r_frame_width;
        if (r_frame_width == '0) begin
            width_eff = DIM_W'(1);
        end else if (int'(r_frame_width) > MAX_WIDTH) begin
            width_eff = DIM_W'(MAX_WIDTH);
        end
        height_eff = r_frame_height;
        if (r_frame_height == '0) begin
            height_eff = DIM_W'(1);
        end else if (int'(r_frame_height) > MAX_HEIGHT) begin
            height_eff = DIM_W'(MAX_HEIGHT);
        end
    end

    mrc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_hold  (clearing),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_op    (i_s_axis_tuser),
        .i_tdata (i_s_axis_tdata),
        .o_valid (front_valid),
        .i_ready (!q_full),
        .o_cmd   (front_cmd)
    );

    mrc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_valid && !q_full),
        .i_data  (front_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_cmd),
        .i_pop   (q_pop)
    );

    mrc_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_width     (width_eff),
        .i_height    (height_eff),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_cmd),
        .o_cmd_pop   (q_pop),
        .o_clearing  (clearing),
        .o_res_valid (o_m_axis_tvalid),
        .i_res_ready (i_m_axis_tready),
        .o_res       (res)
    );

    assign o_m_axis_tdata = {(M_TDATA_W - 2 * COORD_W - 1)'(0), res.hit, res.end_y, res.end_x};

endmodule

FILE: sim/mask_ray_cast_tb.sv
// Self-checking testbench for mask_ray_cast: mask writes and ray casts against a local walk model.
module mask_ray_cast_tb;

    import mrc_pkg::*;

    localparam int FRAME_MAX  = 256;
    localparam int IDLE_WAIT  = 20;
    localparam int DRAIN_WAIT = 600;
    localparam int RANDOM_ITEMS = 1200;

    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_CHOKE,
        RX_COMB
    } t_rx_mode;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata = '0;
    logic                   s_tuser = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [DIM_W-1:0]       cfg_wdata = '0;

    // local copy of the block state
    bit                     obstacle_bits [0:FRAME_MAX*FRAME_MAX-1];
    logic [DIM_W-1:0]       frame_cols = 9'd256;
    logic [DIM_W-1:0]       frame_rows = 9'd256;
    t_result                pending_ends [$];

    int                     mismatch_count = 0;
    int                     burst_left = 0;
    bit                     sender_gaps = 1'b1;
    t_rx_mode               rx_mode = RX_OPEN;
    int                     rx_left = 0;
    int                     rx_tick = 0;
    t_result                seen_end;
    t_result                want_end;

    mask_ray_cast u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_wdata     (cfg_wdata)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    function automatic int eff_dim(input logic [DIM_W-1:0] val);
        if (val == 0) return 1;
        return (val > FRAME_MAX) ? FRAME_MAX : int'(val);
    endfunction

    function automatic logic signed [COORD_W-1:0] clamp_coord(input int val);
        if (val > COORD_MAX) return COORD_W'(COORD_MAX);
        if (val < COORD_MIN) return COORD_W'(COORD_MIN);
        return COORD_W'(val);
    endfunction

    // Walk the digital line from the center and return where it stops.
    function automatic t_result cast_ray(input logic signed [COORD_W-1:0] rx,
                                         input logic signed [COORD_W-1:0] ry,
                                         input logic ue,
                                         input logic signed [COORD_W-1:0] ex,
                                         input logic signed [COORD_W-1:0] ey);
        int irx, iry, iex, iey, ax, ay, bxa, bya, sx, sy, u, v;
        int px, py, cols, rows, col, row, stop_x, stop_y;
        bit hit, done;
        t_result res;
        irx = rx;
        iry = ry;
        iex = ex;
        iey = ey;
        ax  = (irx < 0) ? -irx : irx;
        ay  = (iry < 0) ? -iry : iry;
        bxa = (iex < 0) ? -iex : iex;
        bya = (iey < 0) ? -iey : iey;
        sx  = (irx < 0) ? -1 : 1;
        sy  = (iry < 0) ? -1 : 1;
        cols = eff_dim(frame_cols);
        rows = eff_dim(frame_rows);
        u = 0;
        v = 0;
        hit = 1'b0;
        done = 1'b0;
        stop_x = 0;
        stop_y = 0;
        while (!done) begin
            if (ax == 0) begin
                v++;
            end else if (ay == 0) begin
                u++;
            end else if (ay <= ax) begin
                if (ay * u > ax * v) v++;
                u++;
            end else begin
                if (ax * v > ay * u) u++;
                v++;
            end
            px = u * sx;
            py = v * sy;
            col = px + cols / 2;
            row = rows / 2 - py;
            // pixels outside the frame read as clear
            if (col >= 0 && col < cols && row >= 0 && row < rows
                    && obstacle_bits[row * cols + col]) begin
                stop_x = px;
                stop_y = py;
                hit = 1'b1;
                done = 1'b1;
            end else if (u > ax || v > ay) begin
                if (!ue) begin
                    stop_x = irx;
                    stop_y = iry;
                    done = 1'b1;
                end else if (u > bxa || v > bya) begin
                    stop_x = iex;
                    stop_y = iey;
                    done = 1'b1;
                end
            end
        end
        res.end_x = clamp_coord(stop_x);
        res.end_y = clamp_coord(stop_y);
        res.hit   = hit;
        return res;
    endfunction

    task automatic flag_mismatch(input string msg);
        mismatch_count++;
        $display("mismatch at %0t: %s", $time, msg);
    endtask

    // Send one beat, with sender gaps between bursts; predict on acceptance.
    task automatic send_item(input t_op op, input logic [IDX_W-1:0] idx, input logic set,
                             input logic signed [COORD_W-1:0] rx,
                             input logic signed [COORD_W-1:0] ry,
                             input logic ue,
                             input logic signed [COORD_W-1:0] ex,
                             input logic signed [COORD_W-1:0] ey);
        int gap;
        @(negedge clk);
        if (burst_left == 0) begin
            if (sender_gaps) begin
                gap = $urandom_range(1, 12);
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {6'b0, ey, ex, ue, ry, rx, set, idx};
        do @(posedge clk); while (!s_tready);
        burst_left--;
        if (op == OP_WRITE)
            obstacle_bits[idx] = set;
        else
            pending_ends.push_back(cast_ray(rx, ry, ue, ex, ey));
    endtask

    task automatic write_pixel(input int idx, input logic set);
        send_item(OP_WRITE, IDX_W'(idx), set, COORD_W'($urandom), COORD_W'($urandom),
                  1'($urandom), COORD_W'($urandom), COORD_W'($urandom));
    endtask

    task automatic cast_item(input int rx, input int ry, input logic ue,
                             input int ex, input int ey);
        send_item(OP_CAST, IDX_W'($urandom), 1'($urandom), COORD_W'(rx), COORD_W'(ry), ue,
                  COORD_W'(ex), COORD_W'(ey));
    endtask

    // Drop valid and hold until every pending end point has come back.
    task automatic wait_idle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_ends.size() != 0) @(posedge clk);
        repeat (IDLE_WAIT) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [DIM_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        if (idx == REG_FRAME_WIDTH)
            frame_cols = val;
        else
            frame_rows = val;
    endtask

    task automatic set_frame(input logic [DIM_W-1:0] cols, input logic [DIM_W-1:0] rows);
        wait_idle();
        write_register(REG_FRAME_WIDTH, cols);
        write_register(REG_FRAME_HEIGHT, rows);
    endtask

    function automatic logic signed [COORD_W-1:0] rand_coord(input int lim);
        if ($urandom_range(0, 9) == 0) return COORD_W'($urandom_range(0, 1023));
        return COORD_W'($urandom_range(0, 2 * lim) - lim);
    endfunction

    task automatic test_default_frame();
        write_pixel(128 * 256 + 133, 1'b1);     // obstacle at (5, 0)
        cast_item(20, 0, 1'b0, 0, 0);
        cast_item(511, 0, 1'b0, 0, 0);
        write_pixel(125 * 256 + 128, 1'b1);     // obstacle at (0, 3)
        cast_item(0, 0, 1'b0, 0, 0);            // zero reach stops after one probe
        cast_item(0, 0, 1'b1, 0, 511);
        cast_item(-512, -512, 1'b0, 0, 0);      // runs off the frame
        cast_item(511, 511, 1'b1, -512, 511);
        write_pixel(65535, 1'b1);
        write_pixel(65535, 1'b0);
        write_pixel(0, 1'b1);                   // top-left corner
        cast_item(-200, 200, 1'b0, 0, 0);
        cast_item(-300, 200, 1'b1, 511, -512);
        write_pixel(128 * 256 + 133, 1'b0);
        cast_item(20, 0, 1'b0, 0, 0);
        cast_item(6, 1, 1'b1, 100, -3);
    endtask

    task automatic test_frame_limits();
        set_frame(9'd0, 9'd0);                  // zero acts as one
        write_pixel(0, 1'b1);
        cast_item(3, -2, 1'b0, 0, 0);
        set_frame(9'd0, 9'd511);                // one column, clamped height
        write_pixel(120, 1'b1);                 // (0, 8)
        cast_item(0, 20, 1'b0, 0, 0);
        set_frame(9'd511, 9'd0);                // clamped width, one row
        write_pixel(135, 1'b1);                 // (7, 0)
        cast_item(30, 0, 1'b0, 0, 0);
        cast_item(-30, 0, 1'b1, -512, 0);
    endtask

    task automatic test_random_traffic(input int total);
        logic [DIM_W-1:0] phase_cols [8] = '{256, 16, 33, 0, 300, 8, 64, 255};
        logic [DIM_W-1:0] phase_rows [8] = '{256, 16, 9, 0, 40, 511, 64, 17};
        int per_phase, cols, rows, lim, pick, col, row;
        per_phase = total / 8;
        for (int ph = 0; ph < 8; ph++) begin
            set_frame(phase_cols[ph], phase_rows[ph]);
            sender_gaps = ph[0];
            cols = eff_dim(frame_cols);
            rows = eff_dim(frame_rows);
            lim = ((cols > rows) ? cols : rows) / 2 + 6;
            for (int n = 0; n < per_phase; n++) begin
                if (n == per_phase / 2) wait_idle();
                pick = $urandom_range(0, 99);
                if (pick < 40) begin
                    // obstacles clustered around the center, where rays start
                    col = cols / 2 + $urandom_range(0, 24) - 12;
                    row = rows / 2 + $urandom_range(0, 24) - 12;
                    col = (col < 0) ? 0 : ((col >= cols) ? cols - 1 : col);
                    row = (row < 0) ? 0 : ((row >= rows) ? rows - 1 : row);
                    write_pixel(row * cols + col, $urandom_range(0, 2) != 0);
                end else if (pick < 45) begin
                    write_pixel($urandom_range(0, 65535), 1'($urandom_range(0, 1)));
                end else if (pick < 50) begin
                    write_pixel($urandom_range(0, cols * rows - 1),
                                1'($urandom_range(0, 1)));
                end else begin
                    cast_item(rand_coord(lim), rand_coord(lim), 1'($urandom_range(0, 1)),
                              rand_coord(lim), rand_coord(lim));
                end
            end
        end
    endtask

    // Receiver stall pattern, changing to a random mode whenever its countdown runs out.
    always @(negedge clk) begin
        if (rx_left == 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 3));
            rx_left = $urandom_range(40, 400);
        end else begin
            rx_left--;
        end
        rx_tick++;
        case (rx_mode)
            RX_OPEN:  m_tready <= 1'b1;
            RX_COIN:  m_tready <= ($urandom_range(0, 1) == 1);
            RX_CHOKE: m_tready <= ($urandom_range(0, 7) == 0);
            default:  m_tready <= ((rx_tick % 7) >= 3);
        endcase
    end

    // Check each result beat against the oldest pending end point.
    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready) begin
            seen_end = t_result'(m_tdata[2*COORD_W:0]);
            if (pending_ends.size() == 0) begin
                flag_mismatch($sformatf("unexpected beat x=%0d y=%0d hit=%0b",
                              seen_end.end_x, seen_end.end_y, seen_end.hit));
            end else begin
                want_end = pending_ends.pop_front();
                if (seen_end.end_x !== want_end.end_x)
                    flag_mismatch($sformatf("end_x got %0d want %0d",
                                  seen_end.end_x, want_end.end_x));
                if (seen_end.end_y !== want_end.end_y)
                    flag_mismatch($sformatf("end_y got %0d want %0d",
                                  seen_end.end_y, want_end.end_y));
                if (seen_end.hit !== want_end.hit)
                    flag_mismatch($sformatf("hit got %0b want %0b",
                                  seen_end.hit, want_end.hit));
            end
        end
    end

    initial begin
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        test_default_frame();
        test_frame_limits();
        test_random_traffic(RANDOM_ITEMS);
        wait_idle();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (pending_ends.size() != 0)
            flag_mismatch($sformatf("%0d end points never came", pending_ends.size()));
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial begin
        #50000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
